// ===== hw/rtl/i2cm_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C master register access: shared package
// Field structs, bus step codes, the per-command stage sequence and the
// configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cm_pkg;

    // Command item: one bus tick with an optional command.
    typedef struct packed {
        logic       cmd_valid;
        logic       opcode;
        logic [7:0] device_byte;
        logic [7:0] register_index;
        logic [7:0] write_value;
        logic       sda_sample;
    } cmd_t;

    // Result item: line levels and status after the tick.
    typedef struct packed {
        logic       scl_level;
        logic       sda_pull_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_value;
        logic       ack_missing;
    } res_t;

    localparam int unsigned STEP_W  = 5;
    localparam int unsigned STAGE_W = 4;
    localparam int unsigned CNT_W   = 4;
    localparam int unsigned DELAY_W = 16;

    typedef logic [STEP_W-1:0]  step_t;
    typedef logic [STAGE_W-1:0] stage_t;

    // Bus micro-step codes.
    localparam step_t ST_IDLE  = 5'd0;
    localparam step_t ST_SA    = 5'd1;
    localparam step_t ST_SB    = 5'd2;
    localparam step_t ST_TPREP = 5'd3;
    localparam step_t ST_TBIT  = 5'd4;
    localparam step_t ST_TLOW  = 5'd5;
    localparam step_t ST_AA    = 5'd6;
    localparam step_t ST_AB    = 5'd7;
    localparam step_t ST_AC    = 5'd8;
    localparam step_t ST_PA    = 5'd9;
    localparam step_t ST_PB    = 5'd10;
    localparam step_t ST_PC    = 5'd11;
    localparam step_t ST_GAP   = 5'd12;
    localparam step_t ST_RA    = 5'd13;
    localparam step_t ST_RC    = 5'd14;
    localparam step_t ST_RD    = 5'd15;
    localparam step_t ST_NA    = 5'd16;
    localparam step_t ST_NB    = 5'd17;
    localparam step_t ST_FIN   = 5'd18;

    // Stage bookkeeping.
    localparam stage_t STAGE_LAST     = 4'd9;
    localparam stage_t STAGE_DEV      = 4'd1;
    localparam stage_t STAGE_REG      = 4'd2;
    localparam stage_t STAGE_WR_ABORT = 4'd5;
    localparam stage_t STAGE_RD_ABORT = 4'd8;
    localparam logic [CNT_W-1:0] BITS_PER_BYTE = 4'd8;

    // Configuration register indexes and reset values.
    localparam logic CFG_PHASE = 1'b0;
    localparam logic CFG_GAP   = 1'b1;
    localparam logic [DELAY_W-1:0] PHASE_RESET = 16'd200;
    localparam logic [DELAY_W-1:0] GAP_RESET   = 16'd50;

    // Opcode values.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // Step that opens each stage of a write or a read transaction.
    function automatic step_t stage_step(input logic rd, input stage_t stage);
        step_t s;
        s = ST_FIN;
        if (rd == OP_READ) begin
            case (stage)
                4'd0:    s = ST_SA;
                4'd1:    s = ST_TPREP;
                4'd2:    s = ST_TPREP;
                4'd3:    s = ST_PA;
                4'd4:    s = ST_GAP;
                4'd5:    s = ST_SA;
                4'd6:    s = ST_TPREP;
                4'd7:    s = ST_RA;
                4'd8:    s = ST_PA;
                default: s = ST_FIN;
            endcase
        end
        else begin
            case (stage)
                4'd0:    s = ST_SA;
                4'd1:    s = ST_TPREP;
                4'd2:    s = ST_TPREP;
                4'd3:    s = ST_GAP;
                4'd4:    s = ST_TPREP;
                4'd5:    s = ST_PA;
                default: s = ST_FIN;
            endcase
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/i2c_master_register_access.sv =====
// ----------------------------------------------------------------------------
// I2C master register access
// Tick-driven I2C master for single-byte register writes and reads.
// ----------------------------------------------------------------------------
// Each item on the req channel is one bus tick: it carries the sampled SDA
// level and, while the master is idle, an optional write or read command.
// Each accepted tick yields exactly one item on the rsp channel with the SCL
// and SDA drive levels, busy, a one-tick done pulse, the last read byte and
// the missing-acknowledge flag.
// The result is registered and presented in the cycle after acceptance, and
// one tick is accepted in every clock cycle while the receiver does not stall;
// the whole step update is one pass through the sequencer logic into the result register.
// When the receiver stalls, the result register holds its item and req_stall
// rises in the same cycle, so no tick is accepted until the result is taken.
// Bus timing is counted in ticks: phase_ticks between line changes and
// gap_ticks before a write's data byte or between the two parts of a read.
// Configuration is written through cfg_write, cfg_index and cfg_data while
// the block is idle. Reset returns the sequencer to idle with SCL and SDA
// released, the registers to 200 and 50, and the result channel empty.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_register_access (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_write,
    input  wire logic                         cfg_index,
    input  wire logic [i2cm_pkg::DELAY_W-1:0] cfg_data,
    input  wire logic                         req_valid,
    output logic                              req_stall,
    input  wire i2cm_pkg::cmd_t               req,
    output logic                              rsp_valid,
    input  wire logic                         rsp_stall,
    output i2cm_pkg::res_t                    rsp
);

    // Configuration registers.
    logic [i2cm_pkg::DELAY_W-1:0] phase_reg;
    logic [i2cm_pkg::DELAY_W-1:0] gap_reg;

    // Sequencer state.
    i2cm_pkg::step_t              step_reg,    step_next;
    i2cm_pkg::stage_t             stage_reg,   stage_next;
    logic [i2cm_pkg::CNT_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [i2cm_pkg::DELAY_W-1:0] delay_reg,   delay_next;
    logic [7:0]                   shift_reg,   shift_next;
    logic                         op_reg,      op_next;
    logic [7:0]                   dev_reg,     dev_next;
    logic [7:0]                   regidx_reg,  regidx_next;
    logic [7:0]                   wdata_reg,   wdata_next;
    logic [7:0]                   rx_reg,      rx_next;
    logic                         err_reg,     err_next;
    logic                         scl_reg,     scl_next;
    logic                         sdal_reg,    sdal_next;
    logic                         done;

    // Result register.
    logic                         rsp_valid_reg;
    i2cm_pkg::res_t               rsp_reg;

    logic                         accept;
    logic [i2cm_pkg::CNT_W-1:0]   bit_cnt_inc;
    i2cm_pkg::stage_t             stage_adv;
    logic [7:0]                   tx_byte;

    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Helpers: bit count increment, next stage, and the byte for this stage.
    assign bit_cnt_inc = bit_cnt_reg + 1'b1;
    assign stage_adv   = (stage_reg < i2cm_pkg::STAGE_LAST) ? stage_reg + 1'b1 : stage_reg;

    always_comb
    begin
        if (stage_reg == i2cm_pkg::STAGE_DEV) begin
            tx_byte = dev_reg;
        end
        else if (stage_reg == i2cm_pkg::STAGE_REG) begin
            tx_byte = regidx_reg;
        end
        else if (op_reg == i2cm_pkg::OP_READ) begin
            tx_byte = dev_reg | 8'h01;
        end
        else begin
            tx_byte = wdata_reg;
        end
    end

    // Step sequencer: one tick of bus work.
    always_comb
    begin
        step_next    = step_reg;
        stage_next   = stage_reg;
        bit_cnt_next = bit_cnt_reg;
        delay_next   = delay_reg;
        shift_next   = shift_reg;
        op_next      = op_reg;
        dev_next     = dev_reg;
        regidx_next  = regidx_reg;
        wdata_next   = wdata_reg;
        rx_next      = rx_reg;
        err_next     = err_reg;
        scl_next     = scl_reg;
        sdal_next    = sdal_reg;
        done         = 1'b0;

        if (step_reg == i2cm_pkg::ST_IDLE) begin
            if (req.cmd_valid) begin
                op_next      = req.opcode;
                dev_next     = req.device_byte;
                regidx_next  = req.register_index;
                wdata_next   = req.write_value;
                err_next     = 1'b0;
                stage_next   = '0;
                delay_next   = '0;
                bit_cnt_next = '0;
                step_next    = i2cm_pkg::ST_SA;
            end
        end
        else if (delay_reg != '0) begin
            delay_next = delay_reg - 1'b1;
        end
        else begin
            delay_next = phase_reg;
            unique case (step_reg)
                i2cm_pkg::ST_SA:
                begin
                    scl_next  = 1'b1;
                    sdal_next = 1'b0;
                    step_next = i2cm_pkg::ST_SB;
                end
                i2cm_pkg::ST_SB:
                begin
                    sdal_next  = 1'b1;
                    stage_next = stage_adv;
                    step_next  = i2cm_pkg::stage_step(op_reg, stage_adv);
                end
                i2cm_pkg::ST_TPREP:
                begin
                    scl_next     = 1'b0;
                    shift_next   = tx_byte;
                    bit_cnt_next = '0;
                    step_next    = i2cm_pkg::ST_TBIT;
                end
                i2cm_pkg::ST_TBIT:
                begin
                    sdal_next  = !shift_reg[7];
                    shift_next = {shift_reg[6:0], 1'b0};
                    scl_next   = 1'b1;
                    step_next  = i2cm_pkg::ST_TLOW;
                end
                i2cm_pkg::ST_TLOW:
                begin
                    scl_next     = 1'b0;
                    bit_cnt_next = bit_cnt_inc;
                    step_next    = (bit_cnt_inc >= i2cm_pkg::BITS_PER_BYTE) ?
                                   i2cm_pkg::ST_AA : i2cm_pkg::ST_TBIT;
                end
                i2cm_pkg::ST_AA:
                begin
                    scl_next  = 1'b0;
                    sdal_next = 1'b0;
                    step_next = i2cm_pkg::ST_AB;
                end
                i2cm_pkg::ST_AB:
                begin
                    scl_next  = 1'b1;
                    step_next = i2cm_pkg::ST_AC;
                end
                i2cm_pkg::ST_AC:
                begin
                    scl_next = 1'b0;
                    // A released SDA here means the slave did not acknowledge.
                    if (req.sda_sample) begin
                        err_next   = 1'b1;
                        stage_next = (op_reg == i2cm_pkg::OP_READ) ?
                                     i2cm_pkg::STAGE_RD_ABORT : i2cm_pkg::STAGE_WR_ABORT;
                        step_next  = i2cm_pkg::ST_PA;
                    end
                    else begin
                        stage_next = stage_adv;
                        step_next  = i2cm_pkg::stage_step(op_reg, stage_adv);
                    end
                end
                i2cm_pkg::ST_PA:
                begin
                    sdal_next = 1'b1;
                    scl_next  = 1'b0;
                    step_next = i2cm_pkg::ST_PB;
                end
                i2cm_pkg::ST_PB:
                begin
                    scl_next  = 1'b1;
                    step_next = i2cm_pkg::ST_PC;
                end
                i2cm_pkg::ST_PC:
                begin
                    sdal_next  = 1'b0;
                    stage_next = stage_adv;
                    step_next  = i2cm_pkg::stage_step(op_reg, stage_adv);
                end
                i2cm_pkg::ST_GAP:
                begin
                    delay_next = gap_reg;
                    stage_next = stage_adv;
                    step_next  = i2cm_pkg::stage_step(op_reg, stage_adv);
                end
                i2cm_pkg::ST_RA:
                begin
                    scl_next     = 1'b0;
                    sdal_next    = 1'b0;
                    bit_cnt_next = '0;
                    shift_next   = '0;
                    step_next    = i2cm_pkg::ST_RC;
                end
                i2cm_pkg::ST_RC:
                begin
                    scl_next  = 1'b1;
                    step_next = i2cm_pkg::ST_RD;
                end
                i2cm_pkg::ST_RD:
                begin
                    shift_next   = {shift_reg[6:0], req.sda_sample};
                    bit_cnt_next = bit_cnt_inc;
                    scl_next     = 1'b0;
                    step_next    = (bit_cnt_inc >= i2cm_pkg::BITS_PER_BYTE) ?
                                   i2cm_pkg::ST_NA : i2cm_pkg::ST_RC;
                end
                i2cm_pkg::ST_NA:
                begin
                    sdal_next = 1'b0;
                    scl_next  = 1'b1;
                    step_next = i2cm_pkg::ST_NB;
                end
                i2cm_pkg::ST_NB:
                begin
                    scl_next   = 1'b0;
                    rx_next    = shift_reg;
                    stage_next = stage_adv;
                    step_next  = i2cm_pkg::stage_step(op_reg, stage_adv);
                end
                default:
                begin
                    // Finish, and any unused code: back to idle with a done pulse.
                    done       = 1'b1;
                    step_next  = i2cm_pkg::ST_IDLE;
                    delay_next = '0;
                end
            endcase
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= i2cm_pkg::PHASE_RESET;
            gap_reg   <= i2cm_pkg::GAP_RESET;
        end
        else if (cfg_write) begin
            if (cfg_index == i2cm_pkg::CFG_PHASE) begin
                phase_reg <= cfg_data;
            end
            else begin
                gap_reg <= cfg_data;
            end
        end
    end

    // Sequencer state advances once per accepted tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            step_reg    <= i2cm_pkg::ST_IDLE;
            stage_reg   <= '0;
            bit_cnt_reg <= '0;
            delay_reg   <= '0;
            shift_reg   <= '0;
            op_reg      <= 1'b0;
            dev_reg     <= '0;
            regidx_reg  <= '0;
            wdata_reg   <= '0;
            rx_reg      <= '0;
            err_reg     <= 1'b0;
            scl_reg     <= 1'b1;
            sdal_reg    <= 1'b0;
        end
        else if (accept) begin
            step_reg    <= step_next;
            stage_reg   <= stage_next;
            bit_cnt_reg <= bit_cnt_next;
            delay_reg   <= delay_next;
            shift_reg   <= shift_next;
            op_reg      <= op_next;
            dev_reg     <= dev_next;
            regidx_reg  <= regidx_next;
            wdata_reg   <= wdata_next;
            rx_reg      <= rx_next;
            err_reg     <= err_next;
            scl_reg     <= scl_next;
            sdal_reg    <= sdal_next;
        end
    end

    // Result register: loaded on every accepted tick, emptied when taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rsp_valid_reg <= 1'b0;
        end
        else if (accept) begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall) begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            rsp_reg.scl_level    <= scl_next;
            rsp_reg.sda_pull_low <= sdal_next;
            rsp_reg.busy_res     <= (step_next != i2cm_pkg::ST_IDLE);
            rsp_reg.done_res     <= done;
            rsp_reg.read_value   <= rx_next;
            rsp_reg.ack_missing  <= err_next;
        end
    end

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// Testbench for the I2C master register access block
// Drives one bus tick per item, with commands and sampled SDA levels, and
// checks every result item against a cycle-exact model of the sequencer.
// A table of directed transfers comes first. Random transfers follow under
// three idling regimes, and the run ends with idle ticks at the largest
// phase setting.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Run sizing. The directed transfers take about 1500 ticks and the random
    // part a few hundred more; even with the heaviest idling this limit leaves
    // wide headroom.
    localparam int RANDOM_TICKS   = 240;
    localparam int CYCLE_LIMIT    = 200_000;
    localparam int HOLDOFF_CYCLES = 60;
    localparam int CMD_W          = $bits(i2cm_pkg::cmd_t);

    // Stages that carry an acknowledge, besides the address and register
    // bytes, and a marker for a transfer in which every byte is acknowledged.
    localparam i2cm_pkg::stage_t STG_WR_DATA = 4'd4;
    localparam i2cm_pkg::stage_t STG_RD_DEV2 = 4'd6;
    localparam i2cm_pkg::stage_t STG_NONE    = 4'd15;
    localparam logic [7:0] READ_BIT = 8'h01;

    // Step that opens each stage of a transfer.
    localparam i2cm_pkg::step_t WRITE_PLAN [0:9] = '{
        i2cm_pkg::ST_SA, i2cm_pkg::ST_TPREP, i2cm_pkg::ST_TPREP, i2cm_pkg::ST_GAP,
        i2cm_pkg::ST_TPREP, i2cm_pkg::ST_PA, i2cm_pkg::ST_FIN, i2cm_pkg::ST_FIN,
        i2cm_pkg::ST_FIN, i2cm_pkg::ST_FIN};
    localparam i2cm_pkg::step_t READ_PLAN  [0:9] = '{
        i2cm_pkg::ST_SA, i2cm_pkg::ST_TPREP, i2cm_pkg::ST_TPREP, i2cm_pkg::ST_PA,
        i2cm_pkg::ST_GAP, i2cm_pkg::ST_SA, i2cm_pkg::ST_TPREP, i2cm_pkg::ST_RA,
        i2cm_pkg::ST_PA, i2cm_pkg::ST_FIN};

    // One directed transfer: optional timing, the command, the acknowledge
    // to withhold, the byte the slave returns, and the outcome where it is
    // plain to see.
    typedef struct packed {
        logic             cfg;
        logic [15:0]      phase;
        logic [15:0]      gap;
        logic             op;
        logic [7:0]       dev;
        logic [7:0]       regi;
        logic [7:0]       data;
        i2cm_pkg::stage_t nack;
        logic [7:0]       rd;
        logic             typed;
        logic [7:0]       rv;
        logic             am;
    } xfer_row_t;

    typedef struct packed {
        logic       typed;
        logic [7:0] rv;
        logic       am;
    } completion_t;

    localparam xfer_row_t DIRECTED_XFERS [0:15] = '{
        // First transfer after reset: nothing has been read yet.
        '{1'b1, 16'd0, 16'd0, i2cm_pkg::OP_WRITE, 8'hA0, 8'h10, 8'h5A, STG_NONE, 8'h00,
          1'b1, 8'h00, 1'b0},
        '{1'b1, 16'd0, 16'd0, i2cm_pkg::OP_READ,  8'hA0, 8'h00, 8'h00, STG_NONE, 8'hFF,
          1'b1, 8'hFF, 1'b0},
        '{1'b1, 16'd0, 16'd0, i2cm_pkg::OP_READ,  8'hFF, 8'hFF, 8'hFF, STG_NONE, 8'h00,
          1'b1, 8'h00, 1'b0},
        '{1'b1, 16'd1, 16'd1, i2cm_pkg::OP_WRITE, 8'h00, 8'h00, 8'h00, STG_NONE, 8'h00,
          1'b1, 8'h00, 1'b0},
        '{1'b1, 16'd0, 16'd0, i2cm_pkg::OP_WRITE, 8'hFF, 8'hFF, 8'hFF, STG_NONE, 8'h00,
          1'b1, 8'h00, 1'b0},
        // Missing acknowledge on each byte of a write.
        '{1'b0, 16'd0, 16'd0, i2cm_pkg::OP_WRITE, 8'h5A, 8'h3C, 8'h81,
          i2cm_pkg::STAGE_DEV, 8'h00, 1'b1, 8'h00, 1'b1},
        '{1'b0, 16'd0, 16'd0, i2cm_pkg::OP_WRITE, 8'h5A, 8'h3C, 8'h81,
          i2cm_pkg::STAGE_REG, 8'h00, 1'b1, 8'h00, 1'b1},
        '{1'b0, 16'd0, 16'd0, i2cm_pkg::OP_WRITE, 8'h5A, 8'h3C, 8'h81, STG_WR_DATA, 8'h00,
          1'b1, 8'h00, 1'b1},
        '{1'b1, 16'd1, 16'd3, i2cm_pkg::OP_READ,  8'hA6, 8'h42, 8'h00, STG_NONE, 8'hA5,
          1'b1, 8'hA5, 1'b0},
        // Aborted reads keep the last byte read.
        '{1'b1, 16'd0, 16'd0, i2cm_pkg::OP_READ,  8'hA6, 8'h42, 8'h00,
          i2cm_pkg::STAGE_DEV, 8'h00, 1'b1, 8'hA5, 1'b1},
        '{1'b0, 16'd0, 16'd0, i2cm_pkg::OP_READ,  8'hA6, 8'h42, 8'h00,
          i2cm_pkg::STAGE_REG, 8'h00, 1'b1, 8'hA5, 1'b1},
        '{1'b0, 16'd0, 16'd0, i2cm_pkg::OP_READ,  8'hA6, 8'h42, 8'h00, STG_RD_DEV2, 8'h00,
          1'b1, 8'hA5, 1'b1},
        '{1'b0, 16'd0, 16'd0, i2cm_pkg::OP_WRITE, 8'h5A, 8'h01, 8'hC3, STG_NONE, 8'h00,
          1'b1, 8'hA5, 1'b0},
        '{1'b1, 16'd0, 16'd1, i2cm_pkg::OP_READ,  8'h01, 8'h7F, 8'h00, STG_NONE, 8'h3C,
          1'b1, 8'h3C, 1'b0},
        '{1'b1, 16'd0, 16'd5, i2cm_pkg::OP_READ,  8'h80, 8'h80, 8'h80, STG_NONE, 8'h81,
          1'b1, 8'h81, 1'b0},
        '{1'b1, 16'd3, 16'd2, i2cm_pkg::OP_WRITE, 8'h80, 8'h01, 8'h7E, STG_NONE, 8'h00,
          1'b1, 8'h81, 1'b0}
    };

    logic             clk;
    logic             rst_n;
    logic             cfg_write;
    logic             cfg_index;
    logic [15:0]      cfg_data;
    logic             req_valid;
    logic             req_stall;
    i2cm_pkg::cmd_t   req;
    logic             rsp_valid;
    logic             rsp_stall;
    i2cm_pkg::res_t   rsp;

    // Sequencer model state.
    logic [15:0]      phase_len;
    logic [15:0]      gap_len;
    i2cm_pkg::step_t  seq_step;
    i2cm_pkg::stage_t seq_stage;
    logic [3:0]       bit_count;
    logic [15:0]      wait_left;
    logic [7:0]       shift_reg;
    logic [7:0]       rx_byte;
    logic             nack_seen;
    logic             lvl_scl;
    logic             lvl_sda_low;
    logic             cmd_op;
    logic [7:0]       cmd_dev;
    logic [7:0]       cmd_reg;
    logic [7:0]       cmd_data;

    i2cm_pkg::res_t   pending_bus_levels [$];
    completion_t      completion_checks [$];
    i2cm_pkg::res_t   due;
    completion_t      outcome;
    int               mismatches;
    int               ticks_sent;
    int               cycle_count;
    int               send_idle_pct;
    int               recv_stall_pct;
    bit               holdoff_request;

    i2c_master_register_access DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit.
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Return the model to its reset state.
    task automatic reset_sequencer();
        phase_len   = i2cm_pkg::PHASE_RESET;
        gap_len     = i2cm_pkg::GAP_RESET;
        seq_step    = i2cm_pkg::ST_IDLE;
        seq_stage   = '0;
        bit_count   = '0;
        wait_left   = '0;
        shift_reg   = '0;
        rx_byte     = '0;
        nack_seen   = 1'b0;
        lvl_scl     = 1'b1;
        lvl_sda_low = 1'b0;
        cmd_op      = i2cm_pkg::OP_WRITE;
        cmd_dev     = '0;
        cmd_reg     = '0;
        cmd_data    = '0;
    endtask

    // Move to the next stage of the latched transfer.
    task automatic next_stage();
        if (seq_stage < i2cm_pkg::STAGE_LAST)
            seq_stage = seq_stage + 1'b1;
        seq_step = (cmd_op == i2cm_pkg::OP_READ) ? READ_PLAN[seq_stage]
                                                 : WRITE_PLAN[seq_stage];
    endtask

    // Byte sent in the current stage.
    function automatic logic [7:0] outgoing_byte();
        if (seq_stage == i2cm_pkg::STAGE_DEV)
            return cmd_dev;
        if (seq_stage == i2cm_pkg::STAGE_REG)
            return cmd_reg;
        if (cmd_op == i2cm_pkg::OP_READ)
            return cmd_dev | READ_BIT;
        return cmd_data;
    endfunction

    // Advance the sequencer by one tick and give the line levels and status
    // that follow it.
    task automatic next_bus_levels(input i2cm_pkg::cmd_t c, output i2cm_pkg::res_t r);
        logic        done;
        logic [15:0] p;
        done = 1'b0;
        p = phase_len;
        if (seq_step == i2cm_pkg::ST_IDLE)
        begin
            if (c.cmd_valid)
            begin
                cmd_op    = c.opcode;
                cmd_dev   = c.device_byte;
                cmd_reg   = c.register_index;
                cmd_data  = c.write_value;
                nack_seen = 1'b0;
                seq_stage = '0;
                wait_left = '0;
                bit_count = '0;
                seq_step  = i2cm_pkg::ST_SA;
            end
        end
        else if (wait_left != '0)
        begin
            wait_left = wait_left - 1'b1;
        end
        else
        begin
            case (seq_step)
                i2cm_pkg::ST_SA:
                begin
                    lvl_scl = 1'b1; lvl_sda_low = 1'b0; wait_left = p;
                    seq_step = i2cm_pkg::ST_SB;
                end
                i2cm_pkg::ST_SB:
                begin
                    lvl_sda_low = 1'b1; wait_left = p; next_stage();
                end
                i2cm_pkg::ST_TPREP:
                begin
                    lvl_scl = 1'b0; shift_reg = outgoing_byte(); bit_count = '0;
                    wait_left = p; seq_step = i2cm_pkg::ST_TBIT;
                end
                i2cm_pkg::ST_TBIT:
                begin
                    lvl_sda_low = ~shift_reg[7];
                    shift_reg = shift_reg << 1;
                    lvl_scl = 1'b1; wait_left = p; seq_step = i2cm_pkg::ST_TLOW;
                end
                i2cm_pkg::ST_TLOW:
                begin
                    lvl_scl = 1'b0; bit_count = bit_count + 1'b1; wait_left = p;
                    seq_step = (bit_count >= i2cm_pkg::BITS_PER_BYTE) ? i2cm_pkg::ST_AA
                                                                     : i2cm_pkg::ST_TBIT;
                end
                i2cm_pkg::ST_AA:
                begin
                    lvl_scl = 1'b0; lvl_sda_low = 1'b0; wait_left = p;
                    seq_step = i2cm_pkg::ST_AB;
                end
                i2cm_pkg::ST_AB:
                begin
                    lvl_scl = 1'b1; wait_left = p; seq_step = i2cm_pkg::ST_AC;
                end
                i2cm_pkg::ST_AC:
                begin
                    lvl_scl = 1'b0; wait_left = p;
                    if (c.sda_sample)
                    begin
                        // No acknowledge: flag it and go straight to STOP.
                        nack_seen = 1'b1;
                        seq_stage = (cmd_op == i2cm_pkg::OP_READ) ?
                                    i2cm_pkg::STAGE_RD_ABORT : i2cm_pkg::STAGE_WR_ABORT;
                        seq_step = i2cm_pkg::ST_PA;
                    end
                    else
                        next_stage();
                end
                i2cm_pkg::ST_PA:
                begin
                    lvl_sda_low = 1'b1; lvl_scl = 1'b0; wait_left = p;
                    seq_step = i2cm_pkg::ST_PB;
                end
                i2cm_pkg::ST_PB:
                begin
                    lvl_scl = 1'b1; wait_left = p; seq_step = i2cm_pkg::ST_PC;
                end
                i2cm_pkg::ST_PC:
                begin
                    lvl_sda_low = 1'b0; wait_left = p; next_stage();
                end
                i2cm_pkg::ST_GAP:
                begin
                    wait_left = gap_len; next_stage();
                end
                i2cm_pkg::ST_RA:
                begin
                    lvl_scl = 1'b0; lvl_sda_low = 1'b0; bit_count = '0; shift_reg = '0;
                    wait_left = p; seq_step = i2cm_pkg::ST_RC;
                end
                i2cm_pkg::ST_RC:
                begin
                    lvl_scl = 1'b1; wait_left = p; seq_step = i2cm_pkg::ST_RD;
                end
                i2cm_pkg::ST_RD:
                begin
                    shift_reg = {shift_reg[6:0], c.sda_sample};
                    bit_count = bit_count + 1'b1;
                    lvl_scl = 1'b0; wait_left = p;
                    seq_step = (bit_count >= i2cm_pkg::BITS_PER_BYTE) ? i2cm_pkg::ST_NA
                                                                     : i2cm_pkg::ST_RC;
                end
                i2cm_pkg::ST_NA:
                begin
                    lvl_sda_low = 1'b0; lvl_scl = 1'b1; wait_left = p;
                    seq_step = i2cm_pkg::ST_NB;
                end
                i2cm_pkg::ST_NB:
                begin
                    lvl_scl = 1'b0; rx_byte = shift_reg; wait_left = p; next_stage();
                end
                default:
                begin
                    done = 1'b1; seq_step = i2cm_pkg::ST_IDLE; wait_left = '0;
                end
            endcase
        end
        r.scl_level    = lvl_scl;
        r.sda_pull_low = lvl_sda_low;
        r.busy_res     = (seq_step != i2cm_pkg::ST_IDLE);
        r.done_res     = done;
        r.read_value   = rx_byte;
        r.ack_missing  = nack_seen;
    endtask

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    // Accepted ticks feed the model; accepted results are checked in order.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
            begin
                next_bus_levels(req, due);
                pending_bus_levels.push_back(due);
            end
            if (rsp_valid && !rsp_stall)
            begin
                if (pending_bus_levels.size() == 0)
                begin
                    $error("result item arrived with none expected");
                    mismatches++;
                end
                else
                begin
                    due = pending_bus_levels.pop_front();
                    compare_field("scl_level", 8'(due.scl_level), 8'(rsp.scl_level));
                    compare_field("sda_pull_low", 8'(due.sda_pull_low),
                                  8'(rsp.sda_pull_low));
                    compare_field("busy_res", 8'(due.busy_res), 8'(rsp.busy_res));
                    compare_field("done_res", 8'(due.done_res), 8'(rsp.done_res));
                    compare_field("read_value", due.read_value, rsp.read_value);
                    compare_field("ack_missing", 8'(due.ack_missing), 8'(rsp.ack_missing));
                end
                // Outcomes typed into the directed table are checked on the done pulse.
                if (rsp.done_res === 1'b1 && completion_checks.size() != 0)
                begin
                    outcome = completion_checks.pop_front();
                    if (outcome.typed)
                    begin
                        compare_field("read_value", outcome.rv, rsp.read_value);
                        compare_field("ack_missing", 8'(outcome.am), 8'(rsp.ack_missing));
                    end
                end
            end
        end
    end

    // Receiver: random stalls, with a long hold-off on request.
    initial
    begin
        int holdoff_left;
        holdoff_left = 0;
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holdoff_left > 0)
            begin
                holdoff_left--;
                rsp_stall <= 1'b1;
            end
            else if (holdoff_request)
            begin
                holdoff_request = 1'b0;
                holdoff_left = HOLDOFF_CYCLES;
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Offer one tick and wait until it is taken. Called and left at a
    // falling edge.
    task automatic send_tick(input i2cm_pkg::cmd_t c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req <= c;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        @(negedge clk);
        ticks_sent++;
    endtask

    task automatic idle_ticks(input int n);
        i2cm_pkg::cmd_t c;
        repeat (n)
        begin
            c = i2cm_pkg::cmd_t'(CMD_W'($urandom));
            c.cmd_valid = 1'b0;
            send_tick(c);
        end
    endtask

    // Stop offering ticks until every result is in and the block is quiet.
    task automatic drain();
        req_valid <= 1'b0;
        while (pending_bus_levels.size() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_write <= 1'b1;
        @(negedge clk);
        cfg_write <= 1'b0;
        if (idx == i2cm_pkg::CFG_PHASE)
            phase_len = val;
        else
            gap_len = val;
    endtask

    // One transfer from the command tick to the done pulse. The slave side
    // answers on the ticks that sample SDA: it withholds the acknowledge at
    // the chosen stage and returns the given byte; noise makes SDA random.
    task automatic run_transfer(input logic op, input logic [7:0] dev,
                                input logic [7:0] regi, input logic [7:0] data,
                                input i2cm_pkg::stage_t nack, input logic [7:0] rd,
                                input logic noise, input logic typed,
                                input logic [7:0] rv, input logic am);
        i2cm_pkg::cmd_t c;
        completion_t    oc;
        oc.typed = typed;
        oc.rv    = rv;
        oc.am    = am;
        completion_checks.push_back(oc);
        c = i2cm_pkg::cmd_t'(CMD_W'($urandom));
        c.cmd_valid      = 1'b1;
        c.opcode         = op;
        c.device_byte    = dev;
        c.register_index = regi;
        c.write_value    = data;
        send_tick(c);
        while (seq_step != i2cm_pkg::ST_IDLE)
        begin
            // Commands offered while busy must be ignored.
            c = i2cm_pkg::cmd_t'(CMD_W'($urandom));
            c.cmd_valid = ($urandom_range(3) == 0);
            if (noise)
                c.sda_sample = 1'($urandom_range(1));
            else if (wait_left == '0 && seq_step == i2cm_pkg::ST_AC)
                c.sda_sample = (seq_stage == nack);
            else if (wait_left == '0 && seq_step == i2cm_pkg::ST_RD)
                c.sda_sample = rd[3'd7 - bit_count[2:0]];
            send_tick(c);
        end
    endtask

    task automatic random_transfer();
        logic             op;
        i2cm_pkg::stage_t nack;
        logic             noise;
        op = 1'($urandom_range(1));
        nack = STG_NONE;
        if ($urandom_range(9) < 3)
        begin
            case ($urandom_range(2))
                0:       nack = i2cm_pkg::STAGE_DEV;
                1:       nack = i2cm_pkg::STAGE_REG;
                default: nack = (op == i2cm_pkg::OP_READ) ? STG_RD_DEV2 : STG_WR_DATA;
            endcase
        end
        noise = ($urandom_range(9) == 0);
        run_transfer(op, 8'($urandom), 8'($urandom), 8'($urandom), nack, 8'($urandom),
                     noise, 1'b0, 8'h00, 1'b0);
    endtask

    // Mostly fast bus timing so that many transfers fit in the run.
    task automatic random_timing();
        drain();
        if ($urandom_range(4) == 0)
            write_reg(i2cm_pkg::CFG_PHASE, 16'($urandom_range(4, 2)));
        else
            write_reg(i2cm_pkg::CFG_PHASE, 16'($urandom_range(1)));
        write_reg(i2cm_pkg::CFG_GAP, 16'($urandom_range(8)));
    endtask

    // Main stimulus.
    initial
    begin
        xfer_row_t row;
        int        start_tick;
        int        n_xfers;
        mismatches      = 0;
        ticks_sent      = 0;
        holdoff_request = 1'b0;
        send_idle_pct   = 36;
        recv_stall_pct  = 74;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        cfg_write = 1'b0;
        cfg_index = i2cm_pkg::CFG_PHASE;
        cfg_data  = '0;
        reset_sequencer();
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed transfers.
        for (int i = 0; i < 16; i++)
        begin
            row = DIRECTED_XFERS[i];
            if (row.cfg)
            begin
                drain();
                write_reg(i2cm_pkg::CFG_PHASE, row.phase);
                write_reg(i2cm_pkg::CFG_GAP, row.gap);
            end
            run_transfer(row.op, row.dev, row.regi, row.data, row.nack, row.rd, 1'b0,
                         row.typed, row.rv, row.am);
            idle_ticks($urandom_range(3));
        end

        // Random transfers under three idling regimes.
        for (int ph = 0; ph < 3; ph++)
        begin
            drain();
            send_idle_pct  = (ph == 0) ? 36 : (ph == 1) ? 74 : 0;
            recv_stall_pct = (ph == 0) ? 74 : (ph == 1) ? 36 : 0;
            random_timing();
            if (ph < 2)
                holdoff_request = 1'b1;
            start_tick = ticks_sent;
            n_xfers = 0;
            while (ticks_sent - start_tick < RANDOM_TICKS / 3)
            begin
                if (n_xfers % 5 == 4)
                    random_timing();
                random_transfer();
                idle_ticks($urandom_range(3));
                n_xfers++;
            end
        end

        // Largest phase: idle ticks only, since a transfer would not fit in the run limit.
        drain();
        write_reg(i2cm_pkg::CFG_PHASE, 16'hFFFF);
        idle_ticks(20);

        drain();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
